@@ rtl/rbd_pkg.sv @@
// types and constants shared by the ring buffer deque
package rbd_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned PosW   = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned EntryW = 2 * CoordW;

  // request codes
  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ       = 3'd4,
    MODE_WRITE      = 3'd5
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

@@ rtl/rbd_if.sv @@
// request and response channel interfaces of the ring buffer deque
interface rbd_req_if;
  logic                                valid;
  logic                                ready;
  rbd_pkg::mode_e                      mode;
  logic                                from_back;
  logic [rbd_pkg::PosW-1:0]            position;
  logic signed [rbd_pkg::CoordW-1:0]   coord_x;
  logic signed [rbd_pkg::CoordW-1:0]   coord_y;

  modport source (output valid, mode, from_back, position, coord_x, coord_y, input ready);
  modport sink   (input valid, mode, from_back, position, coord_x, coord_y, output ready);
endinterface

interface rbd_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [rbd_pkg::CoordW-1:0]   out_x;
  logic signed [rbd_pkg::CoordW-1:0]   out_y;
  rbd_pkg::status_e                    status;
  logic [rbd_pkg::CountW-1:0]          count;

  modport source (output valid, out_x, out_y, status, count, input ready);
  modport sink   (input valid, out_x, out_y, status, count, output ready);
endinterface

@@ rtl/rbd_ram.sv @@
// generic single-port ram with registered read
module rbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

@@ rtl/ring_buffer_deque_top.sv @@
// ring buffer deque: double-ended queue of coordinate pairs in a circular ram
//
// Requests arrive as words on req_i (push back/front, pop front/back, read or
// write at an index counted from either end). Each accepted request gives one
// response word on rsp_o with the entry read or removed, a status code and
// the entry count after the request. Refused requests (push when full, pop
// when empty, index at or past the count) leave the state alone.
// The response is registered: it is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while rsp_o is not stalled; each request
// makes at most one access to the single-port entry ram at its accept edge, and
// the head and count registers are updated at that same edge, so the next
// request sees them. The read data is held in the ram output register, which
// only reloads when a new request is accepted.
// Stall: while a response waits and rsp_o.ready is low, req_i.ready is low.
// Reset: head and count clear to zero at once, no clearing pass; the ram
// contents are undefined until written and are never read before that.
module ring_buffer_deque_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rbd_req_if.sink        req_i,
  rbd_rsp_if.source      rsp_o
);

  import rbd_pkg::*;

  localparam int unsigned PtrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  // circular slot of head + offset, offset below CAPACITY
  function automatic logic [PtrW-1:0] slot_of(input logic [PtrW-1:0] base,
                                             input logic [PtrW-1:0] offs);
    logic [PtrW:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (PtrW+1)'(CAPACITY)) begin
      sum = sum - (PtrW+1)'(CAPACITY);
    end
    return sum[PtrW-1:0];
  endfunction

  logic [PtrW-1:0]   head_q, head_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic              out_valid_q;
  logic              rd_q, rd_d;
  status_e           status_q, status_d;
  logic [CountW-1:0] count_q;

  logic              accept;
  logic              full, empty, range_bad;
  logic [CmpW-1:0]   pos_c, fill_c, idx_c;
  logic [PtrW-1:0]   offs;
  logic [PtrW-1:0]   addr;
  logic              we, re;
  logic [EntryW-1:0] wdata, rdata;

  // handshake
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // index arithmetic
  assign full      = (fill_q == CntW'(CAPACITY));
  assign empty     = (fill_q == '0);
  assign pos_c     = CmpW'(req_i.position);
  assign fill_c    = CmpW'(fill_q);
  assign range_bad = (pos_c >= fill_c);
  assign idx_c     = req_i.from_back ? (fill_c - CmpW'(1) - pos_c) : pos_c;
  assign wdata     = {req_i.coord_y, req_i.coord_x};

  // request decode: pointer update and the one ram access
  always_comb begin
    head_d   = head_q;
    fill_d   = fill_q;
    rd_d     = 1'b0;
    status_d = ST_OK;
    we       = 1'b0;
    re       = 1'b0;
    offs     = '0;
    addr     = head_q;
    unique case (req_i.mode)
      MODE_PUSH_BACK: begin
        offs = PtrW'(fill_q);
        addr = slot_of(head_q, offs);
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we     = 1'b1;
          fill_d = fill_q + CntW'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        addr = (head_q == '0) ? PtrW'(CAPACITY - 1) : head_q - PtrW'(1);
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we     = 1'b1;
          head_d = addr;
          fill_d = fill_q + CntW'(1);
        end
      end
      MODE_POP_FRONT: begin
        offs = PtrW'(1);
        addr = head_q;
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          re     = 1'b1;
          rd_d   = 1'b1;
          head_d = slot_of(head_q, offs);
          fill_d = fill_q - CntW'(1);
        end
      end
      MODE_POP_BACK: begin
        offs = PtrW'(fill_q - CntW'(1));
        addr = slot_of(head_q, offs);
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          re     = 1'b1;
          rd_d   = 1'b1;
          fill_d = fill_q - CntW'(1);
        end
      end
      MODE_READ, MODE_WRITE: begin
        offs = PtrW'(idx_c);
        addr = slot_of(head_q, offs);
        if (range_bad) begin
          status_d = ST_RANGE;
        end else if (req_i.mode == MODE_READ) begin
          re   = 1'b1;
          rd_d = 1'b1;
        end else begin
          we = 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // entry store
  rbd_ram #(
    .WIDTH (EntryW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept && we),
    .re_i    (accept && re),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // pointer and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else if (accept) begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // response word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q     <= rd_d;
      status_q <= status_d;
      count_q  <= CountW'(fill_d);
    end
  end

  // response outputs
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.out_x  = rd_q ? rdata[CoordW-1:0] : '0;
  assign rsp_o.out_y  = rd_q ? rdata[EntryW-1:CoordW] : '0;
  assign rsp_o.status = status_q;
  assign rsp_o.count  = count_q;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// testbench of the ring buffer deque: random deque traffic checked against a mirror of the queue

import rbd_pkg::*;

localparam int unsigned DequeDepth = 64;

// spare request codes that the block must treat as no-ops
localparam logic [2:0] MODE_SPARE_A = 3'd6;
localparam logic [2:0] MODE_SPARE_B = 3'd7;

typedef struct packed {
  mode_e                    mode;
  logic                     from_back;
  logic [PosW-1:0]          position;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
} request_t;

typedef struct packed {
  logic signed [CoordW-1:0] out_x;
  logic signed [CoordW-1:0] out_y;
  status_e                  status;
  logic [CountW-1:0]        count;
} reply_t;

// mirror of the deque contents plus the replies still owed by the block
class deque_tracker;
  logic [EntryW-1:0] slots [DequeDepth];
  bit [PosW-1:0]     head;
  bit [CountW-1:0]   fill;
  reply_t            awaited[$];
  int                errors;

  function new();
    head   = '0;
    fill   = '0;
    errors = 0;
    foreach (slots[i]) slots[i] = '0;
  endfunction

  function bit [PosW-1:0] slot_at(int unsigned offset);
    return PosW'((head + offset) % DequeDepth);
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  task report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // apply one accepted request to the mirror and queue the reply it owes
  function void note_request(request_t rq);
    reply_t            rs;
    logic [EntryW-1:0] picked;
    int unsigned       logical;
    picked    = '0;
    rs.status = ST_OK;
    case (rq.mode)
      MODE_PUSH_BACK: begin
        if (fill >= DequeDepth) begin
          rs.status = ST_FULL;
        end else begin
          slots[slot_at(fill)] = {rq.coord_y, rq.coord_x};
          fill++;
        end
      end
      MODE_PUSH_FRONT: begin
        if (fill >= DequeDepth) begin
          rs.status = ST_FULL;
        end else begin
          head        = PosW'((head + DequeDepth - 1) % DequeDepth);
          slots[head] = {rq.coord_y, rq.coord_x};
          fill++;
        end
      end
      MODE_POP_FRONT: begin
        if (fill == 0) begin
          rs.status = ST_EMPTY;
        end else begin
          picked = slots[head];
          head   = slot_at(1);
          fill--;
        end
      end
      MODE_POP_BACK: begin
        if (fill == 0) begin
          rs.status = ST_EMPTY;
        end else begin
          picked = slots[slot_at(fill - 1)];
          fill--;
        end
      end
      MODE_READ, MODE_WRITE: begin
        if (rq.position >= fill) begin
          rs.status = ST_RANGE;
        end else begin
          logical = rq.from_back ? (fill - 1 - rq.position) : rq.position;
          if (rq.mode == MODE_READ) picked = slots[slot_at(logical)];
          else slots[slot_at(logical)] = {rq.coord_y, rq.coord_x};
        end
      end
      default: ;
    endcase
    rs.out_x = picked[CoordW-1:0];
    rs.out_y = picked[EntryW-1:CoordW];
    rs.count = fill;
    awaited.push_back(rs);
  endfunction

  // compare one accepted reply with the oldest owed one
  task check_reply(reply_t got);
    reply_t want;
    if (awaited.size() == 0) begin
      report($sformatf("reply with none owed: x=%0d y=%0d status=%0d count=%0d",
                       got.out_x, got.out_y, got.status, got.count));
      return;
    end
    want = awaited.pop_front();
    if (got.out_x !== want.out_x)
      report($sformatf("out_x got %0d want %0d", got.out_x, want.out_x));
    if (got.out_y !== want.out_y)
      report($sformatf("out_y got %0d want %0d", got.out_y, want.out_y));
    if (got.status !== want.status)
      report($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.count !== want.count)
      report($sformatf("count got %0d want %0d", got.count, want.count));
  endtask
endclass

module tb_top;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  logic clk_i;
  logic rst_ni;
  bit   calm;

  rbd_req_if req_if ();
  rbd_rsp_if rsp_if ();

  deque_tracker sb;

  ring_buffer_deque_top #(
    .CAPACITY(DequeDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // present one request word and hold it until accepted
  task automatic drive_request(request_t rq);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.mode      <= rq.mode;
    req_if.from_back <= rq.from_back;
    req_if.position  <= rq.position;
    req_if.coord_x   <= rq.coord_x;
    req_if.coord_y   <= rq.coord_y;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(rq);
  endtask

  task automatic send(mode_e m, logic fb, logic [PosW-1:0] pos,
                      logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y);
    request_t rq;
    rq = '{mode: m, from_back: fb, position: pos, coord_x: x, coord_y: y};
    drive_request(rq);
  endtask

  // random request, biased towards growing, shrinking or holding the queue
  function automatic request_t make_request(phase_e kind);
    request_t rq;
    int       r;
    int       push_lim;
    int       pop_lim;
    case (kind)
      PH_FILL: begin
        push_lim = 60;
        pop_lim  = 75;
      end
      PH_DRAIN: begin
        push_lim = 15;
        pop_lim  = 75;
      end
      default: begin
        push_lim = 35;
        pop_lim  = 70;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < push_lim)
      rq.mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    else if (r < pop_lim)
      rq.mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
    else if (r < 98)
      rq.mode = $urandom_range(0, 1) ? MODE_READ : MODE_WRITE;
    else
      rq.mode = mode_e'($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B);
    rq.from_back = 1'($urandom_range(0, 1));
    rq.coord_x   = CoordW'($urandom_range(0, 65535));
    rq.coord_y   = CoordW'($urandom_range(0, 65535));
    // mostly indexes that hit a held entry, some anywhere
    if ((rq.mode == MODE_READ || rq.mode == MODE_WRITE) && sb.fill != 0 &&
        $urandom_range(0, 9) < 8)
      rq.position = PosW'($urandom_range(0, sb.fill - 1));
    else
      rq.position = PosW'($urandom_range(0, 63));
    return rq;
  endfunction

  // reply side: random stalls, check every accepted reply word
  initial begin
    reply_t got;
    int     gap;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (rsp_if.valid !== 1'b1) @(posedge clk_i);
      got.out_x  = rsp_if.out_x;
      got.out_y  = rsp_if.out_y;
      got.status = rsp_if.status;
      got.count  = rsp_if.count;
      sb.check_reply(got);
    end
  end

  // stimulus
  initial begin
    phase_e kind;
    sb = new();
    calm = 1'b0;
    rst_ni <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.mode      <= MODE_PUSH_BACK;
    req_if.from_back <= 1'b0;
    req_if.position  <= '0;
    req_if.coord_x   <= '0;
    req_if.coord_y   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // refusals on an empty queue and the spare codes
    send(MODE_POP_FRONT, 1'b0, 6'd0, 16'sd0, 16'sd0);
    send(MODE_POP_BACK, 1'b1, 6'd0, 16'sd0, 16'sd0);
    send(MODE_READ, 1'b0, 6'd0, 16'sd0, 16'sd0);
    send(MODE_WRITE, 1'b1, 6'd63, 16'sh7fff, 16'sh7fff);
    send(mode_e'(MODE_SPARE_A), 1'b1, 6'd63, -16'sd1, -16'sd1);
    send(mode_e'(MODE_SPARE_B), 1'b0, 6'd0, 16'sd0, 16'sd0);
    // extremes at both ends, head wrapping below slot zero
    send(MODE_PUSH_BACK, 1'b0, 6'd0, 16'sh7fff, -16'sh8000);
    send(MODE_PUSH_FRONT, 1'b1, 6'd63, -16'sh8000, 16'sh7fff);
    send(MODE_PUSH_BACK, 1'b1, 6'd0, 16'sd0, -16'sd1);
    send(MODE_PUSH_FRONT, 1'b0, 6'd0, -16'sd1, 16'sd0);
    // reads from either end, in and out of range
    send(MODE_READ, 1'b0, 6'd0, 16'sd0, 16'sd0);
    send(MODE_READ, 1'b1, 6'd0, 16'sd0, 16'sd0);
    send(MODE_READ, 1'b0, 6'd3, 16'sd0, 16'sd0);
    send(MODE_READ, 1'b1, 6'd3, 16'sd0, 16'sd0);
    send(MODE_READ, 1'b0, 6'd4, 16'sd0, 16'sd0);
    send(MODE_READ, 1'b1, 6'd63, 16'sd0, 16'sd0);
    // overwrites in place
    send(MODE_WRITE, 1'b1, 6'd1, 16'sh5555, -16'sh5556);
    send(MODE_WRITE, 1'b0, 6'd1, -16'sh5556, 16'sh5555);
    send(MODE_READ, 1'b0, 6'd2, 16'sd0, 16'sd0);
    // drain from both ends past empty
    send(MODE_POP_BACK, 1'b1, 6'd0, -16'sd1, -16'sd1);
    send(MODE_POP_FRONT, 1'b1, 6'd0, 16'sd0, 16'sd0);
    send(MODE_POP_FRONT, 1'b0, 6'd0, 16'sd0, 16'sd0);
    send(MODE_POP_BACK, 1'b0, 6'd0, 16'sd0, 16'sd0);
    send(MODE_POP_FRONT, 1'b0, 6'd0, 16'sd0, 16'sd0);

    // random phases that fill to capacity, drain to empty and churn
    for (int ph = 0; ph < 7; ph++) begin
      kind = phase_e'(ph % 3);
      calm = (ph == 2 || ph == 4);
      repeat (250) drive_request(make_request(kind));
    end
    calm = 1'b0;
    req_if.valid <= 1'b0;

    // let the last replies drain
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
